// ----- src/ptq_pkg.sv -----
// ----------------------------------------------------------------------------
// ptq_pkg
// Shared types, sizes and codes of the sorted priority queue.
// ----------------------------------------------------------------------------
package ptq_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int PRIORITY_BITS = 8;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int ID_W     = 16;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int PRIO_W   = 8;
    localparam int COUNT_W  = 5;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_VIEW   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // cell operations
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_HOLD   = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
    localparam logic [OP_W-1:0] OP_POP    = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [OP_W-1:0] OP_ROTATE = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic [PRIORITY_BITS-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic [OP_W-1:0] op;
        t_entry          entry;
    } t_cell_cmd;

endpackage

// ----- src/ptq_in_if.sv -----
// ----------------------------------------------------------------------------
// ptq_in_if
// Request channel of the priority queue: valid, ready and one action beat.
// ----------------------------------------------------------------------------
interface ptq_in_if import ptq_pkg::*;;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [ID_W-1:0]     task_id;
    logic [PRIO_W-1:0]   priority_req;

    modport source (output valid, action, task_id, priority_req, input ready);
    modport sink   (input valid, action, task_id, priority_req, output ready);
endinterface

// ----- src/ptq_out_if.sv -----
// ----------------------------------------------------------------------------
// ptq_out_if
// Result channel of the priority queue: valid, ready and one result beat.
// ----------------------------------------------------------------------------
interface ptq_out_if import ptq_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     out_id;
    logic [PRIO_W-1:0]   out_priority;
    logic [COUNT_W-1:0]  entry_count;
    logic                last;

    modport source (output valid, status, out_id, out_priority, entry_count, last,
                    input ready);
    modport sink   (input valid, status, out_id, out_priority, entry_count, last,
                    output ready);
endinterface

// ----- src/ptq_cell.sv -----
// ----------------------------------------------------------------------------
// ptq_cell
// One slot of the sorted chain: holds an entry and takes its own, a
// neighbor's or the new entry each cycle.
// ----------------------------------------------------------------------------
module ptq_cell import ptq_pkg::*; (
    input  logic      i_clk,
    input  t_cell_cmd i_cmd,
    input  t_entry    i_left,
    input  t_entry    i_right,
    input  t_entry    i_head,
    input  logic      i_occ,
    input  logic      i_tail,
    input  logic      i_prev_ge,
    input  logic      i_prev_seen,
    output t_entry    o_entry,
    output logic      o_ge,
    output logic      o_seen,
    output t_entry    o_hit
);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_match;

    assign w_match = i_occ && (r_entry.id == i_cmd.entry.id);
    assign o_ge    = i_occ && (r_entry.prio >= i_cmd.entry.prio);
    assign o_seen  = i_prev_seen | w_match;
    assign o_hit   = (w_match && !i_prev_seen) ? r_entry : '0;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_cmd.op)
            OP_HOLD: n_entry = r_entry;
            OP_ADD: begin
                // ge is a prefix of the chain: first cell past it takes the new entry
                if (o_ge) begin
                    n_entry = r_entry;
                end else if (i_prev_ge) begin
                    n_entry = i_cmd.entry;
                end else begin
                    n_entry = i_left;
                end
            end
            OP_POP:    n_entry = i_right;
            OP_REMOVE: n_entry = o_seen ? i_right : r_entry;
            OP_ROTATE: n_entry = i_tail ? i_head : i_right;
            default:   n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ----- src/priority_task_queue.sv -----
// ----------------------------------------------------------------------------
// priority_task_queue
// Sorted priority queue with delete by id, built as a chain of entry cells.
// ----------------------------------------------------------------------------
// The result of an accepted request beat is registered in the output register in the cycle after it.
// Add, pop and remove each give one result beat; a new request is taken in every cycle the
// output register is free and no view is in progress.
// View gives one result beat per stored entry (minimum one), the chain rotating one slot a beat.
// Reset empties the queue (entry count zero) and clears the output valid.
// ----------------------------------------------------------------------------
module priority_task_queue import ptq_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ptq_in_if.sink       i_in,
    ptq_out_if.source    o_out
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_VIEW = 1'b1;

    logic             r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_view_idx, n_view_idx;

    logic                r_ov;
    logic [STATUS_W-1:0] r_status, n_status;
    t_entry              r_res, n_res;
    logic                r_last, n_last;
    logic [CNT_W-1:0]    r_res_count;
    logic                w_load;

    logic      w_out_free;
    logic      w_acc;
    t_cell_cmd w_cmd;
    t_entry    w_new;
    t_entry    w_hit;
    logic      w_found;
    logic      w_view_end;

    t_entry c_entry [QUEUE_DEPTH];
    logic   c_ge    [QUEUE_DEPTH];
    logic   c_seen  [QUEUE_DEPTH];
    t_entry c_hit   [QUEUE_DEPTH];

    assign w_out_free = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && w_out_free;
    assign w_acc      = i_in.valid && i_in.ready;

    assign w_new.id   = i_in.task_id;
    assign w_new.prio = i_in.priority_req[PRIORITY_BITS-1:0];

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            ptq_cell u_cell (
                .i_clk      (i_clk),
                .i_cmd      (w_cmd),
                .i_left     (c_entry[(g == 0) ? 0 : g - 1]),
                .i_right    (c_entry[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
                .i_head     (c_entry[0]),
                .i_occ      (CNT_W'(g) < r_count),
                .i_tail     (CNT_W'(g) == (r_count - CNT_W'(1))),
                .i_prev_ge  ((g == 0) ? 1'b1 : c_ge[(g == 0) ? 0 : g - 1]),
                .i_prev_seen((g == 0) ? 1'b0 : c_seen[(g == 0) ? 0 : g - 1]),
                .o_entry    (c_entry[g]),
                .o_ge       (c_ge[g]),
                .o_seen     (c_seen[g]),
                .o_hit      (c_hit[g])
            );
        end
    endgenerate

    // at most one cell flags the first id match
    always_comb begin
        w_hit = '0;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            w_hit = w_hit | c_hit[k];
        end
    end

    assign w_found    = c_seen[QUEUE_DEPTH-1];
    assign w_view_end = (CNT_W'(r_view_idx) == (r_count - CNT_W'(1)));

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_view_idx = r_view_idx;
        w_cmd.op    = OP_HOLD;
        w_cmd.entry = w_new;
        w_load   = 1'b0;
        n_status = ST_OK;
        n_res    = '0;
        n_last   = 1'b1;

        if (r_state == S_IDLE) begin
            if (w_acc) begin
                w_load = 1'b1;
                case (i_in.action)
                    ACT_ADD: begin
                        if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            w_cmd.op = OP_ADD;
                            n_count  = r_count + CNT_W'(1);
                        end
                    end
                    ACT_POP: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            w_cmd.op = OP_POP;
                            n_count  = r_count - CNT_W'(1);
                            n_res    = c_entry[0];
                        end
                    end
                    ACT_REMOVE: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else if (w_found) begin
                            w_cmd.op = OP_REMOVE;
                            n_count  = r_count - CNT_W'(1);
                            n_res    = w_hit;
                        end else begin
                            n_status = ST_NOT_FOUND;
                        end
                    end
                    ACT_VIEW: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            // first beat now, the rest while rotating
                            w_cmd.op = OP_ROTATE;
                            n_res    = c_entry[0];
                            n_last   = (r_count == CNT_W'(1));
                            if (r_count != CNT_W'(1)) begin
                                n_state    = S_VIEW;
                                n_view_idx = IDX_W'(1);
                            end
                        end
                    end
                    default: n_status = ST_OK;
                endcase
            end
        end else begin
            if (w_out_free) begin
                w_load   = 1'b1;
                w_cmd.op = OP_ROTATE;
                n_res    = c_entry[0];
                n_last   = w_view_end;
                n_view_idx = r_view_idx + IDX_W'(1);
                if (w_view_end) begin
                    n_state = S_IDLE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_view_idx <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_view_idx <= n_view_idx;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status    <= n_status;
            r_res       <= n_res;
            r_last      <= n_last;
            r_res_count <= n_count;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.status       = r_status;
    assign o_out.out_id       = r_res.id;
    assign o_out.out_priority = PRIO_W'(r_res.prio);
    assign o_out.entry_count  = COUNT_W'(r_res_count);
    assign o_out.last         = r_last;

endmodule
